// File: hw/rtl/twbsv_pkg.sv
// Shared types and constants for the time window buy/sell volume block.
`default_nettype none

package twbsv_pkg;

    localparam int unsigned TIME_W = 63;
    localparam int unsigned QTY_W  = 48;
    localparam int unsigned SUM_W  = 60;
    localparam int unsigned CFG_W  = 32;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 32'd900000000;

    // Register indexes on the configuration port.
    localparam logic REG_WINDOW = 1'b0;

    typedef struct packed {
        logic [TIME_W-1:0] trade_time_us;
        logic [QTY_W-1:0]  trade_quantity;
        logic              seller_side;
    } t_trade;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_INS,
        S_CHK,
        S_EVC
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/twbsv_if.sv
// Channel interfaces for trade items and volume results.
`default_nettype none

interface twbsv_trade_if;
    logic        valid;
    logic        ready;
    logic [62:0] trade_time_us;
    logic [47:0] trade_quantity;
    logic        seller_side;

    modport source (output valid, trade_time_us, trade_quantity, seller_side, input ready);
    modport sink   (input valid, trade_time_us, trade_quantity, seller_side, output ready);
endinterface

interface twbsv_result_if;
    logic        valid;
    logic        ready;
    logic [59:0] buy_volume;
    logic [59:0] sell_volume;
    logic        window_full;
    logic        ring_overflow;

    modport source (output valid, buy_volume, sell_volume, window_full, ring_overflow,
                    input ready);
    modport sink   (input valid, buy_volume, sell_volume, window_full, ring_overflow,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/time_window_buy_sell_volume.sv
// The back end pops a trade in S_IDLE and writes it to the ring; if the ring is full, it
// first pushes out the oldest entry in S_POP and writes in S_INS. S_CHK steps through
// S_EVC once per trade evicted by age and loads the result register once the output is
// free; a new trade is taken only back in S_IDLE, as the ring has a single read port.
// Reset clears pointers, count, sums and flags and sets the window to 900000000 us;
// ring contents are left as they are and no clearing pass runs.
`default_nettype none

module time_window_buy_sell_volume #(
    parameter int unsigned RING_DEPTH    = 4096,
    parameter int unsigned QUANTITY_BITS = 48
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    twbsv_trade_if.sink      i_trade,
    twbsv_result_if.source   o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [twbsv_pkg::CFG_W-1:0] r_window;
    logic                        q_valid;
    logic                        q_pop;
    twbsv_pkg::t_trade           q_item;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == twbsv_pkg::REG_WINDOW) ? r_window : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= twbsv_pkg::WINDOW_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == twbsv_pkg::REG_WINDOW) begin
            r_window <= pwdata;
        end
    end

    twbsv_front #(
        .QUANTITY_BITS (QUANTITY_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_trade   (i_trade),
        .i_q_pop   (q_pop),
        .o_q_valid (q_valid),
        .o_q_item  (q_item)
    );

    twbsv_back #(
        .RING_DEPTH    (RING_DEPTH),
        .QUANTITY_BITS (QUANTITY_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_window  (r_window),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

// File: hw/rtl/twbsv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module twbsv_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/twbsv_front.sv
// Front end: accepts trades, masks the quantity and queues them for the back end.
`default_nettype none

module twbsv_front #(
    parameter int unsigned QUANTITY_BITS = 48
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    twbsv_trade_if.sink           i_trade,
    input  wire logic             i_q_pop,
    output logic                  o_q_valid,
    output twbsv_pkg::t_trade     o_q_item
);

    localparam int unsigned QW = (QUANTITY_BITS < twbsv_pkg::QTY_W) ?
                                 QUANTITY_BITS : twbsv_pkg::QTY_W;
    localparam logic [twbsv_pkg::QTY_W-1:0] QMASK =
        twbsv_pkg::QTY_W'((64'd1 << QW) - 64'd1);

    twbsv_pkg::t_trade r_q [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              push;
    twbsv_pkg::t_trade in_item;

    assign i_trade.ready = (r_cnt != 2'd2);
    assign push          = i_trade.valid && i_trade.ready;

    always_comb begin
        in_item.trade_time_us  = i_trade.trade_time_us;
        in_item.trade_quantity = i_trade.trade_quantity & QMASK;
        in_item.seller_side    = i_trade.seller_side;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_q_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_q_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_item;
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd];

endmodule

`default_nettype wire

// File: hw/rtl/twbsv_back.sv
// Back end: ring insertion, age eviction, saturating sums and the result register.
`default_nettype none

module twbsv_back #(
    parameter int unsigned RING_DEPTH    = 4096,
    parameter int unsigned QUANTITY_BITS = 48
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [twbsv_pkg::CFG_W-1:0]   i_window,
    input  wire logic                          i_q_valid,
    input  wire twbsv_pkg::t_trade             i_q_item,
    output logic                               o_q_pop,
    twbsv_result_if.source                     o_result
);

    localparam int unsigned TW = twbsv_pkg::TIME_W;
    localparam int unsigned SW = twbsv_pkg::SUM_W;
    localparam int unsigned QW = (QUANTITY_BITS < twbsv_pkg::QTY_W) ?
                                 QUANTITY_BITS : twbsv_pkg::QTY_W;
    localparam int unsigned IW = $clog2(RING_DEPTH);
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);
    localparam int unsigned WW = TW + QW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(RING_DEPTH);

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SW] ? '1 : s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] sat_sub(input logic [SW-1:0] a, input logic [SW-1:0] b);
        return (b > a) ? '0 : a - b;
    endfunction

    twbsv_pkg::t_state r_state, n_state;
    logic [IW-1:0]     r_oldest, n_oldest;
    logic [IW-1:0]     r_newest, n_newest;
    logic [CW-1:0]     r_count, n_count;
    logic [SW-1:0]     r_buy, n_buy;
    logic [SW-1:0]     r_sell, n_sell;
    logic              r_collect, n_collect;
    logic              r_ovf, n_ovf;
    twbsv_pkg::t_trade r_item, n_item;
    logic              r_out_valid, n_out_valid;
    logic [SW-1:0]     r_out_buy, r_out_sell;
    logic              r_out_full, r_out_ovf;
    logic              out_load;

    logic              ram_we;
    logic [IW-1:0]     ram_raddr;
    logic [WW-1:0]     ram_wdata;
    logic [WW-1:0]     ram_rdata;
    twbsv_pkg::t_trade ins_item;

    logic [TW-1:0]     rd_time;
    logic [QW-1:0]     rd_qty;
    logic              rd_side;
    logic [TW-1:0]     age;
    logic              evict;
    logic              full;
    logic [IW-1:0]     oldest_next;
    logic [IW-1:0]     newest_next;

    logic              upd;
    logic              upd_sub;
    logic              upd_side;
    logic [SW-1:0]     upd_qty;
    logic [SW-1:0]     upd_res;

    assign full        = (r_count == FULL_CNT);
    assign oldest_next = (r_oldest == LAST_IDX) ? '0 : r_oldest + IW'(1);
    assign newest_next = (r_newest == LAST_IDX) ? '0 : r_newest + IW'(1);
    assign ins_item    = (r_state == twbsv_pkg::S_IDLE) ? i_q_item : r_item;

    assign ram_wdata = {ins_item.seller_side, ins_item.trade_quantity[QW-1:0],
                        ins_item.trade_time_us};
    assign {rd_side, rd_qty, rd_time} = ram_rdata;

    // The read always follows the head of the ring; in S_EVC it runs ahead by one.
    assign ram_raddr = (r_state == twbsv_pkg::S_EVC) ? oldest_next : r_oldest;

    // When only the new trade is held no eviction is made, as its read may be stale.
    assign age   = r_item.trade_time_us - rd_time;
    assign evict = (r_count > CW'(1)) && (r_item.trade_time_us > rd_time) &&
                   (age > TW'(i_window));

    twbsv_ram #(
        .WIDTH (WW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_newest),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_oldest  = r_oldest;
        n_newest  = r_newest;
        n_count   = r_count;
        n_collect = r_collect;
        n_ovf     = r_ovf;
        n_item    = r_item;
        o_q_pop   = 1'b0;
        ram_we    = 1'b0;
        out_load  = 1'b0;
        upd       = 1'b0;
        upd_sub   = 1'b0;
        upd_side  = ins_item.seller_side;
        upd_qty   = SW'(ins_item.trade_quantity);

        case (r_state)
            twbsv_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    if (full) begin
                        n_ovf   = 1'b1;
                        n_state = twbsv_pkg::S_POP;
                    end else begin
                        n_ovf    = 1'b0;
                        ram_we   = 1'b1;
                        upd      = 1'b1;
                        n_newest = newest_next;
                        n_count  = r_count + CW'(1);
                        n_state  = twbsv_pkg::S_CHK;
                    end
                end
            end
            twbsv_pkg::S_POP: begin
                upd      = 1'b1;
                upd_sub  = 1'b1;
                upd_side = rd_side;
                upd_qty  = SW'(rd_qty);
                n_oldest = oldest_next;
                n_count  = r_count - CW'(1);
                n_state  = twbsv_pkg::S_INS;
            end
            twbsv_pkg::S_INS: begin
                ram_we   = 1'b1;
                upd      = 1'b1;
                n_newest = newest_next;
                n_count  = r_count + CW'(1);
                n_state  = twbsv_pkg::S_CHK;
            end
            twbsv_pkg::S_CHK: begin
                if (evict) begin
                    n_state = twbsv_pkg::S_EVC;
                end else if (!r_out_valid || o_result.ready) begin
                    out_load = 1'b1;
                    n_state  = twbsv_pkg::S_IDLE;
                end
            end
            twbsv_pkg::S_EVC: begin
                upd       = 1'b1;
                upd_sub   = 1'b1;
                upd_side  = rd_side;
                upd_qty   = SW'(rd_qty);
                n_oldest  = oldest_next;
                n_count   = r_count - CW'(1);
                n_collect = 1'b1;
                n_state   = twbsv_pkg::S_CHK;
            end
            default: begin
                n_state = twbsv_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_buy  = r_buy;
        n_sell = r_sell;
        if (upd_sub) begin
            upd_res = sat_sub(upd_side ? r_sell : r_buy, upd_qty);
        end else begin
            upd_res = sat_add(upd_side ? r_sell : r_buy, upd_qty);
        end
        if (upd) begin
            if (upd_side) begin
                n_sell = upd_res;
            end else begin
                n_buy = upd_res;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= twbsv_pkg::S_IDLE;
            r_oldest    <= '0;
            r_newest    <= '0;
            r_count     <= '0;
            r_buy       <= '0;
            r_sell      <= '0;
            r_collect   <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_newest    <= n_newest;
            r_count     <= n_count;
            r_buy       <= n_buy;
            r_sell      <= n_sell;
            r_collect   <= n_collect;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        if (out_load) begin
            r_out_buy  <= r_buy;
            r_out_sell <= r_sell;
            r_out_full <= r_collect;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.buy_volume    = r_out_buy;
    assign o_result.sell_volume   = r_out_sell;
    assign o_result.window_full   = r_out_full;
    assign o_result.ring_overflow = r_out_ovf;

endmodule

`default_nettype wire

// File: test/tb_time_window_buy_sell_volume.sv
// Testbench for the time window buy/sell volume block: trades checked against a volume predictor.
`default_nettype none

typedef struct packed {
    logic [twbsv_pkg::SUM_W-1:0] buy_volume;
    logic [twbsv_pkg::SUM_W-1:0] sell_volume;
    logic                        window_full;
    logic                        ring_overflow;
} t_volume_rec;

class volume_scoreboard;
    int unsigned                  depth;
    logic [twbsv_pkg::TIME_W-1:0] held_time[];
    logic [twbsv_pkg::QTY_W-1:0]  held_qty[];
    logic                         held_sell[];
    int unsigned                  oldest;
    int unsigned                  newest;
    int unsigned                  held_count;
    logic [twbsv_pkg::SUM_W-1:0]  buy_sum;
    logic [twbsv_pkg::SUM_W-1:0]  sell_sum;
    logic                         aged_out;
    logic [twbsv_pkg::CFG_W-1:0]  window_us;
    t_volume_rec                  expected_q[$];
    int unsigned                  errors;

    function new(int unsigned ring_depth);
        depth      = ring_depth;
        held_time  = new[ring_depth];
        held_qty   = new[ring_depth];
        held_sell  = new[ring_depth];
        oldest     = 0;
        newest     = 0;
        held_count = 0;
        buy_sum    = '0;
        sell_sum   = '0;
        aged_out   = 1'b0;
        window_us  = twbsv_pkg::WINDOW_RESET;
        errors     = 0;
    endfunction

    function logic [twbsv_pkg::SUM_W-1:0] add_sat(logic [twbsv_pkg::SUM_W-1:0] a,
                                                  logic [twbsv_pkg::QTY_W-1:0] b);
        logic [twbsv_pkg::SUM_W:0] s;
        s = a + b;
        return s[twbsv_pkg::SUM_W] ? '1 : s[twbsv_pkg::SUM_W-1:0];
    endfunction

    // Takes the oldest held trade out of the ring and out of its side's sum.
    function void drop_oldest();
        if (held_sell[oldest]) begin
            sell_sum = (held_qty[oldest] > sell_sum) ? '0 : sell_sum - held_qty[oldest];
        end else begin
            buy_sum = (held_qty[oldest] > buy_sum) ? '0 : buy_sum - held_qty[oldest];
        end
        oldest = (oldest + 1 == depth) ? 0 : oldest + 1;
        held_count--;
    endfunction

    function void note_trade(logic [twbsv_pkg::TIME_W-1:0] t, logic [twbsv_pkg::QTY_W-1:0] q,
                             logic sell);
        t_volume_rec                  rec;
        logic [twbsv_pkg::TIME_W-1:0] age;
        rec.ring_overflow = 1'b0;
        if (held_count >= depth) begin
            drop_oldest();
            rec.ring_overflow = 1'b1;
        end
        held_time[newest] = t;
        held_qty[newest]  = q;
        held_sell[newest] = sell;
        newest = (newest + 1 == depth) ? 0 : newest + 1;
        held_count++;
        if (sell) begin
            sell_sum = add_sat(sell_sum, q);
        end else begin
            buy_sum = add_sat(buy_sum, q);
        end
        // A held trade newer than this one counts as age zero.
        while (held_count > 0) begin
            age = (t > held_time[oldest]) ? t - held_time[oldest] : '0;
            if (age <= window_us) break;
            drop_oldest();
            aged_out = 1'b1;
        end
        rec.buy_volume  = buy_sum;
        rec.sell_volume = sell_sum;
        rec.window_full = aged_out;
        expected_q.insert(expected_q.size(), rec);
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
        errors++;
        if (errors <= 40) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    function void check_result(t_volume_rec got);
        t_volume_rec want;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result transfer with no trade pending, buy %0d sell %0d",
                     $time, got.buy_volume, got.sell_volume);
            return;
        end
        want = expected_q.pop_front();
        if (got.buy_volume !== want.buy_volume) begin
            report("buy_volume", want.buy_volume, got.buy_volume);
        end
        if (got.sell_volume !== want.sell_volume) begin
            report("sell_volume", want.sell_volume, got.sell_volume);
        end
        if (got.window_full !== want.window_full) begin
            report("window_full", want.window_full, got.window_full);
        end
        if (got.ring_overflow !== want.ring_overflow) begin
            report("ring_overflow", want.ring_overflow, got.ring_overflow);
        end
    endfunction
endclass

module tb_time_window_buy_sell_volume;

    localparam int unsigned RING_DEPTH  = 4096;
    localparam int unsigned IDLE_LIMIT  = 30000;
    localparam int unsigned HOLD_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    twbsv_trade_if  trade_ch ();
    twbsv_result_if result_ch ();

    time_window_buy_sell_volume #(
        .RING_DEPTH    (RING_DEPTH),
        .QUANTITY_BITS (twbsv_pkg::QTY_W)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_trade  (trade_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    volume_scoreboard             sb;
    bit                           no_idle = 1'b0;
    bit                           hold_request = 1'b0;
    logic [twbsv_pkg::TIME_W-1:0] cur_time;
    int unsigned                  quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if ((trade_ch.valid && trade_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        t_volume_rec got;
        stall_left = 0;
        hold_left  = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_ch.valid && result_ch.ready) begin
                got.buy_volume    = result_ch.buy_volume;
                got.sell_volume   = result_ch.sell_volume;
                got.window_full   = result_ch.window_full;
                got.ring_overflow = result_ch.ring_overflow;
                sb.check_result(got);
            end
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                result_ch.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    task automatic send_trade(input logic [twbsv_pkg::TIME_W-1:0] t,
                              input logic [twbsv_pkg::QTY_W-1:0] q, input logic sell);
        int unsigned gap;
        trade_ch.valid          <= 1'b1;
        trade_ch.trade_time_us  <= t;
        trade_ch.trade_quantity <= q;
        trade_ch.seller_side    <= sell;
        do @(posedge i_clk); while (trade_ch.ready !== 1'b1);
        sb.note_trade(t, q, sell);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            trade_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Waits for the block to drain, writes the window register and reads it back.
    task automatic set_window(input logic [twbsv_pkg::CFG_W-1:0] value);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {twbsv_pkg::REG_WINDOW, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.window_us = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== value) begin
            sb.errors++;
            $display("%0t: window register expected %0d, got %0d", $time, value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Timestamps step by amounts scaled to the window so that trades age out
    // at about the rate they arrive, with repeats, full flushes and backward steps.
    task automatic random_trades(input int unsigned count);
        logic [63:0]                 win;
        logic [63:0]                 delta;
        logic [twbsv_pkg::QTY_W-1:0] q;
        int unsigned                 pick;
        repeat (count) begin
            win  = 64'(sb.window_us);
            pick = $urandom_range(0, 99);
            if (pick < 10) delta = '0;
            else if (pick < 70) delta = 64'($urandom_range(0, 32'(win / 8 + 1)));
            else if (pick < 88) delta = win / 2 + 64'($urandom_range(0, 32'(win / 2 + 1)));
            else if (pick < 94) delta = win + 64'd1 + 64'($urandom_range(0, 1000));
            else delta = {$urandom_range(0, 255), $urandom};
            if (pick >= 97 && cur_time > 1000) begin
                cur_time = cur_time - twbsv_pkg::TIME_W'($urandom_range(1, 1000));
            end else begin
                cur_time = cur_time + delta[twbsv_pkg::TIME_W-1:0];
            end
            case ($urandom_range(0, 7))
                0:       q = '0;
                1:       q = '1;
                2, 3:    q = twbsv_pkg::QTY_W'($urandom_range(0, 1000));
                default: q = twbsv_pkg::QTY_W'({$urandom, $urandom});
            endcase
            send_trade(cur_time, q, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        logic [twbsv_pkg::QTY_W-1:0]  qmax;
        logic [twbsv_pkg::TIME_W-1:0] tmax;
        logic [twbsv_pkg::QTY_W-1:0]  q;
        logic [twbsv_pkg::CFG_W-1:0]  windows[6];
        sb = new(RING_DEPTH);
        i_rst_n                 <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        trade_ch.valid          <= 1'b0;
        trade_ch.trade_time_us  <= '0;
        trade_ch.trade_quantity <= '0;
        trade_ch.seller_side    <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        qmax = '1;
        tmax = '1;
        // Window at its reset value: a trade exactly one window old stays held.
        send_trade(0, 0, 1'b0);
        send_trade(0, qmax, 1'b1);
        send_trade(5, qmax, 1'b0);
        send_trade(900000000, 12345, 1'b1);
        send_trade(900000001, 1, 1'b0);
        send_trade(900000000, 7, 1'b1);
        send_trade(900000006, 2, 1'b0);
        send_trade(63'h2AAA_AAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b1);
        send_trade(tmax, qmax, 1'b0);
        send_trade(63'h4000_0000_0000_0000, 1, 1'b1);
        send_trade(tmax, 0, 1'b1);
        trade_ch.valid <= 1'b0;

        set_window('0);
        send_trade(tmax, 3, 1'b0);
        send_trade(tmax, qmax, 1'b1);
        send_trade(tmax, 48'hAAAA_AAAA_AAAA, 1'b0);
        trade_ch.valid <= 1'b0;

        // Build up a long history under a wide window so that the short
        // windows that follow evict it in bulk.
        set_window(32'd3600000000);
        cur_time = twbsv_pkg::TIME_W'({$urandom_range(0, 255), $urandom});
        repeat (300) begin
            cur_time = cur_time + twbsv_pkg::TIME_W'($urandom_range(0, 1000));
            q = ($urandom_range(0, 3) != 0) ? qmax : twbsv_pkg::QTY_W'({$urandom, $urandom});
            send_trade(cur_time, q, 1'($urandom_range(0, 1)));
        end
        trade_ch.valid <= 1'b0;

        windows[0] = 32'd1;
        windows[1] = '0;
        windows[2] = $urandom_range(2, 50000);
        windows[3] = 32'd3600000000;
        windows[4] = '1;
        windows[5] = $urandom;
        foreach (windows[i]) begin
            set_window(windows[i]);
            no_idle = (i == 2);
            if (i == 3) hold_request = 1'b1;
            random_trades(215);
            trade_ch.valid <= 1'b0;
        end
        no_idle = 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
